/* design/tcpd_pkg.sv */
// Shared widths, constants and types of the twelve-channel PDM dimmer.
`default_nettype none
package tcpd_pkg;

	localparam int BYTE_W = 8;
	localparam int ON_W = 12;
	localparam int COUNT_W = 12;
	localparam int MAX_CHANNELS = 16;

	localparam logic [COUNT_W-1:0] RESET_INTERVAL = 12'd180;
	localparam logic [COUNT_W-1:0] INTERVAL_LOW = 12'd200;
	localparam logic [COUNT_W-1:0] INTERVAL_HIGH = 12'd160;
	localparam logic [BYTE_W-1:0] CMP_STEP = 8'd7;
	localparam logic [BYTE_W-1:0] CMP_MSB = 8'h80;
	localparam logic [BYTE_W-1:0] CMP_LOW_MASK = 8'h7F;

	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam logic [BYTE_W-1:0] RESET_LEVELS [MAX_CHANNELS] = '{
		8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
	};

	// Timer status towards the top level.
	typedef struct packed {
		logic              fire;
		logic [BYTE_W-1:0] cmp;
		logic [BYTE_W-1:0] cmp_next;
	} tcpd_timer_t;

endpackage
`default_nettype wire

/* design/tcpd_cmd_if.sv */
// Input channel: serial bytes and timer ticks.
`default_nettype none
interface tcpd_cmd_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [tcpd_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output mode, output rx_byte, input ready);
	modport sink (input valid, input mode, input rx_byte, output ready);
endinterface
`default_nettype wire

/* design/tcpd_res_if.sv */
// Result channel: channel outputs and compare status.
`default_nettype none
interface tcpd_res_if;
	logic                        valid;
	logic                        ready;
	logic [tcpd_pkg::ON_W-1:0]   channel_on;
	logic                        compare_fired;
	logic [tcpd_pkg::BYTE_W-1:0] compare_level;

	modport source (output valid, output channel_on, output compare_fired,
		output compare_level, input ready);
	modport sink (input valid, input channel_on, input compare_fired,
		input compare_level, output ready);
endinterface
`default_nettype wire

/* design/twelve_channel_pdm_dimmer.sv */
// Throughput: one beat per cycle; the input register and the result register
// form a two-stage pipeline that stalls only while the result is not taken.
// Reset: asynchronous, active low; levels load their default pattern, the
// interval loads 180 and the counter, compare value, held pattern and result valid clear.
`default_nettype none
module twelve_channel_pdm_dimmer #(
	parameter int CHANNELS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tcpd_cmd_if.sink  cmd,
	tcpd_res_if.source res
);
	import tcpd_pkg::*;

	logic              valid_s1;
	logic              mode_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;
	logic              step;
	logic              tick;
	logic              fired;
	logic [CHANNELS-1:0] hit;
	logic [CHANNELS-1:0] bits_q;
	logic [CHANNELS-1:0] bits_next;
	logic [MAX_CHANNELS-1:0] wide;
	logic [ON_W-1:0]   on_next;
	logic              res_valid_q;
	logic [ON_W-1:0]   on_q;
	logic              fired_q;
	logic [BYTE_W-1:0] level_q;
	tcpd_timer_t       tst;

	assign advance = !res_valid_q || res.ready;
	assign cmd.ready = !valid_s1 || advance;
	assign step = valid_s1 && advance;
	assign tick = step && (mode_s1 == MODE_TICK);
	assign fired = tick && tst.fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			mode_s1 <= cmd.mode;
			byte_s1 <= cmd.rx_byte;
		end
	end

	tcpd_levels #(
		.CHANNELS(CHANNELS)
	) u_levels (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (step && (mode_s1 == MODE_BYTE)),
		.rx_byte (byte_s1),
		.cmp     (tst.cmp),
		.hit     (hit)
	);

	tcpd_timer u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.st     (tst)
	);

	always_comb begin
		bits_next = fired ? hit : bits_q;
		wide = '0;
		wide[CHANNELS-1:0] = bits_next;
		on_next = wide[ON_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (step) begin
				bits_q <= bits_next;
			end
			if (advance) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			on_q <= on_next;
			fired_q <= fired;
			level_q <= fired ? tst.cmp_next : tst.cmp;
		end
	end

	assign res.valid = res_valid_q;
	assign res.channel_on = on_q;
	assign res.compare_fired = fired_q;
	assign res.compare_level = level_q;

`ifndef SYNTHESIS
	// A serial byte never changes the held output pattern.
	a_byte_keeps_bits: assert property (@(posedge clk) disable iff (!arst_n)
		step && (mode_s1 == MODE_BYTE) |=> $stable(bits_q))
		else $error("output pattern changed on a serial byte");

	// A waiting result always shows the held output pattern.
	a_result_matches_bits: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !step |-> on_q == wide[ON_W-1:0])
		else $error("result pattern differs from held pattern");

	// With the result register empty the input side never stalls.
	a_empty_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> cmd.ready)
		else $error("input stalled with empty result register");

	// The compare value returns to zero only through reset.
	a_cmp_never_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tick && tst.fire |=> tst.cmp != '0)
		else $error("compare value stepped to zero");
`endif

endmodule
`default_nettype wire

/* design/tcpd_levels.sv */
// Channel level store, address/level byte pairing and level compares.
`default_nettype none
module tcpd_levels #(
	parameter int CHANNELS = 12
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [tcpd_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic [tcpd_pkg::BYTE_W-1:0] cmp,
	output logic [CHANNELS-1:0]              hit
);
	import tcpd_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic              phase_q;
	logic [BYTE_W-1:0] target_q;
	logic [BYTE_W-1:0] levels_q [CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			target_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				levels_q[i] <= RESET_LEVELS[i];
			end
		end else if (wr_en) begin
			if (!phase_q) begin
				target_q <= rx_byte;
				phase_q <= 1'b1;
			end else begin
				// Levels for addresses beyond the last channel are dropped.
				if (target_q < BYTE_W'(CHANNELS)) begin
					levels_q[target_q[IDX_W-1:0]] <= rx_byte;
				end
				phase_q <= 1'b0;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			hit[i] = (levels_q[i] >= cmp);
		end
	end

endmodule
`default_nettype wire

/* design/tcpd_timer.sv */
// Tick counter, match interval and interleaved compare sequence.
`default_nettype none
module tcpd_timer (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           tick,
	output tcpd_pkg::tcpd_timer_t st
);
	import tcpd_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] interval_q;
	logic [BYTE_W-1:0]  cmp_q;
	logic [2:0]         band;
	logic [COUNT_W-1:0] interval_next;
	logic [BYTE_W-1:0]  stepped;
	logic               fire;

	assign fire = (count_q >= interval_q);
	assign band = cmp_q[6:4];

	// Intervals grow with the band in the low half of the sequence and shrink with it in the high half.
	always_comb begin
		if (!cmp_q[7]) begin
			interval_next = INTERVAL_LOW * (COUNT_W'(band) + COUNT_W'(1));
		end else begin
			interval_next = INTERVAL_HIGH * (COUNT_W'(16) - COUNT_W'(band));
		end
	end

	always_comb begin
		stepped = (cmp_q + CMP_STEP) & CMP_LOW_MASK;
		if (cmp_q[7]) begin
			st.cmp_next = (stepped == '0) ? CMP_MSB : stepped;
		end else begin
			st.cmp_next = cmp_q | CMP_MSB;
		end
		st.fire = fire;
		st.cmp = cmp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			interval_q <= RESET_INTERVAL;
			cmp_q <= '0;
		end else if (tick) begin
			if (fire) begin
				count_q <= '0;
				interval_q <= interval_next;
				cmp_q <= st.cmp_next;
			end else begin
				count_q <= count_q + COUNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the twelve-channel PDM dimmer: level writes, timer matches, stalls.
module tb;
	import tcpd_pkg::*;

	localparam int CHANNELS = 12;
	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 6;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES = 64;
	localparam int CYCLE_LIMIT = 1_500_000;

	typedef enum int {
		IDLE_NONE,
		IDLE_SHORT,
		IDLE_FULL
	} idle_level_t;

	typedef struct packed {
		logic [ON_W-1:0]   channel_on;
		logic              compare_fired;
		logic [BYTE_W-1:0] compare_level;
	} dimmer_result_t;

	logic clk;
	logic arst_n;

	tcpd_cmd_if cmd_ch ();
	tcpd_res_if res_ch ();

	twelve_channel_pdm_dimmer #(
		.CHANNELS(CHANNELS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.res   (res_ch)
	);

	// Predicted dimmer state.
	logic [BYTE_W-1:0]  model_levels [CHANNELS];
	logic               pair_second;
	logic [BYTE_W-1:0]  pending_channel;
	logic [BYTE_W-1:0]  cmp_now;
	logic [COUNT_W-1:0] interval_now;
	logic [COUNT_W-1:0] ticks_now;
	logic [ON_W-1:0]    lamps_now;
	int                 matches_seen;

	dimmer_result_t expected_results [$];

	bit          failed;
	bit          hold_request;
	idle_level_t send_idle;
	idle_level_t sink_idle;
	int          cycles;

	function automatic dimmer_result_t predict_dimmer(input logic m, input logic [BYTE_W-1:0] b);
		int                q;
		logic              fired;
		logic [BYTE_W-1:0] stepped;
		fired = 1'b0;
		if (m == MODE_BYTE) begin
			if (!pair_second) begin
				pending_channel = b;
				pair_second = 1'b1;
			end else begin
				// A level for an address beyond the last channel is simply dropped.
				if (pending_channel < CHANNELS)
					model_levels[pending_channel[3:0]] = b;
				pair_second = 1'b0;
			end
		end else if (ticks_now >= interval_now) begin
			ticks_now = '0;
			fired = 1'b1;
			matches_seen++;
			q = int'(cmp_now[6:4]);
			if (!cmp_now[7])
				interval_now = COUNT_W'(int'(INTERVAL_LOW) * (q + 1));
			else
				interval_now = COUNT_W'(int'(INTERVAL_HIGH) * (16 - q));
			lamps_now = '0;
			for (int i = 0; i < CHANNELS; i++)
				if (model_levels[i] >= cmp_now)
					lamps_now[i] = 1'b1;
			if (cmp_now[7]) begin
				stepped = (cmp_now + CMP_STEP) & CMP_LOW_MASK;
				if (stepped == '0)
					stepped = CMP_MSB;
			end else begin
				stepped = cmp_now | CMP_MSB;
			end
			cmp_now = stepped;
		end else begin
			ticks_now = ticks_now + COUNT_W'(1);
		end
		return '{channel_on: lamps_now, compare_fired: fired, compare_level: cmp_now};
	endfunction

	function automatic int draw_gap(input idle_level_t lvl);
		int r;
		r = $urandom_range(0, 99);
		case (lvl)
			IDLE_SHORT: begin
				return (r < 70) ? 0 : $urandom_range(1, 3);
			end
			IDLE_FULL: begin
				if (r < 55)
					return 0;
				if (r < 85)
					return $urandom_range(1, 3);
				if (r < 97)
					return $urandom_range(4, 8);
				return $urandom_range(9, 30);
			end
			default: return 0;
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] pick_level();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 8'd0;
		if (r < 30)
			return 8'd255;
		return BYTE_W'($urandom);
	endfunction

	function automatic logic [BYTE_W-1:0] pick_address();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return BYTE_W'($urandom_range(0, CHANNELS - 1));
		if (r < 95)
			return BYTE_W'($urandom_range(CHANNELS, 15));
		return BYTE_W'($urandom_range(16, 255));
	endfunction

	// Offers one beat, waits for it to be taken and records what it should produce.
	task automatic send_beat(input logic m, input logic [BYTE_W-1:0] b);
		int gap;
		gap = draw_gap(send_idle);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.mode <= m;
		cmd_ch.rx_byte <= b;
		do @(posedge clk); while (!cmd_ch.ready);
		expected_results.push_back(predict_dimmer(m, b));
	endtask

	task automatic send_level_pair(input logic [BYTE_W-1:0] addr, input logic [BYTE_W-1:0] lvl);
		send_beat(MODE_BYTE, addr);
		send_beat(MODE_BYTE, lvl);
	endtask

	task automatic finish_phase();
		cmd_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_level_writes();
		send_idle = IDLE_SHORT;
		sink_idle = IDLE_SHORT;
		send_level_pair(8'd0, 8'd255);
		send_level_pair(8'd11, 8'd0);
		send_level_pair(8'd12, 8'h5A);
		send_level_pair(8'd255, 8'hA5);
		send_level_pair(8'd5, 8'd128);
		send_level_pair(8'd3, 8'd1);
		send_level_pair(8'd6, 8'd127);
		send_beat(MODE_TICK, 8'hFF);
		send_beat(MODE_TICK, 8'h00);
		// Ticks between an address and its level must not disturb the pairing.
		send_beat(MODE_BYTE, 8'd9);
		send_beat(MODE_TICK, 8'h55);
		send_beat(MODE_BYTE, 8'd200);
		finish_phase();
	endtask

	task automatic test_reset_interval();
		int target;
		target = matches_seen + 2;
		while (matches_seen < target)
			send_beat(MODE_TICK, BYTE_W'($urandom));
		finish_phase();
	endtask

	task automatic test_random_mix(input int n);
		int sent;
		int r;
		send_idle = IDLE_FULL;
		sink_idle = IDLE_FULL;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				send_level_pair(pick_address(), pick_level());
				sent += 2;
			end else if (r < 50) begin
				// A stray byte throws the address and level pairing out of step.
				send_beat(MODE_BYTE, BYTE_W'($urandom));
				sent++;
			end else begin
				send_beat(MODE_TICK, BYTE_W'($urandom));
				sent++;
			end
		end
		finish_phase();
	endtask

	task automatic test_output_backpressure();
		send_idle = IDLE_NONE;
		hold_request = 1'b1;
		repeat (48) begin
			if ($urandom_range(0, 1) == 0)
				send_beat(MODE_TICK, BYTE_W'($urandom));
			else
				send_beat(MODE_BYTE, BYTE_W'($urandom));
		end
		finish_phase();
	endtask

	task automatic test_match_soak(input int fires_wanted, input int cap);
		int start;
		int sent;
		start = matches_seen;
		sent = 0;
		while (matches_seen - start < fires_wanted && sent < cap) begin
			// Alternate stretches with no idling and with short gaps on both sides.
			if (sent % 500 == 0) begin
				send_idle = ((sent / 500) % 2 == 0) ? IDLE_NONE : IDLE_SHORT;
				sink_idle = send_idle;
			end
			if ($urandom_range(0, 99) < 3) begin
				send_level_pair(pick_address(), pick_level());
				sent += 2;
			end else begin
				send_beat(MODE_TICK, BYTE_W'($urandom));
				sent++;
			end
		end
		finish_phase();
	endtask

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	// Result side: random stalls, plus one long hold when a test asks for it.
	initial begin : result_sink
		int gap;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				res_ch.ready <= 1'b1;
			end else if (sink_idle != IDLE_NONE && $urandom_range(0, 7) == 0) begin
				gap = draw_gap(sink_idle);
				if (gap == 0)
					gap = 1;
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : result_check
		dimmer_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result beat: channel_on %h", res_ch.channel_on);
					failed = 1'b1;
				end else begin
					want = expected_results.pop_front();
					if (res_ch.channel_on !== want.channel_on) begin
						$error("channel_on: expected %h, got %h",
							want.channel_on, res_ch.channel_on);
						failed = 1'b1;
					end
					if (res_ch.compare_fired !== want.compare_fired) begin
						$error("compare_fired: expected %b, got %b",
							want.compare_fired, res_ch.compare_fired);
						failed = 1'b1;
					end
					if (res_ch.compare_level !== want.compare_level) begin
						$error("compare_level: expected %h, got %h",
							want.compare_level, res_ch.compare_level);
						failed = 1'b1;
					end
				end
			end
		end
	end

	initial begin
		failed = 1'b0;
		hold_request = 1'b0;
		send_idle = IDLE_NONE;
		sink_idle = IDLE_NONE;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = MODE_TICK;
		cmd_ch.rx_byte = '0;
		res_ch.ready = 1'b0;
		for (int i = 0; i < CHANNELS; i++)
			model_levels[i] = RESET_LEVELS[i];
		pair_second = 1'b0;
		pending_channel = '0;
		cmp_now = '0;
		interval_now = RESET_INTERVAL;
		ticks_now = '0;
		lamps_now = '0;
		matches_seen = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_level_writes();
		test_reset_interval();
		test_random_mix(800);
		test_output_backpressure();
		test_match_soak(1, 100);
		if (!failed)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule
